// File: design/stsc_pkg.sv
// Shared constants, token kinds and queue word types for the script token scanner.
package stsc_pkg;

  localparam int OFF_W   = 16;
  localparam int KW_LEN  = 8;
  localparam int MAX_TOK = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

  // Token kinds, dense
  localparam logic [5:0] K_EOF = 6'd0,  K_PLUSEQ = 6'd1,  K_PLUS = 6'd2,   K_ARROW = 6'd3;
  localparam logic [5:0] K_MINUSEQ = 6'd4, K_MINUS = 6'd5, K_EXP = 6'd6,   K_MULTEQ = 6'd7;
  localparam logic [5:0] K_MULT = 6'd8, K_MODEQ = 6'd9,  K_MOD = 6'd10,   K_DIVEQ = 6'd11;
  localparam logic [5:0] K_DIV = 6'd12, K_EQEQ = 6'd13,  K_EQ = 6'd14,    K_BANGEQ = 6'd15;
  localparam logic [5:0] K_BANG = 6'd16, K_GTEQ = 6'd17, K_RSHIFT = 6'd18, K_GT = 6'd19;
  localparam logic [5:0] K_LTEQ = 6'd20, K_APPEND = 6'd21, K_LSHIFT = 6'd22, K_LT = 6'd23;
  localparam logic [5:0] K_AND = 6'd24, K_BITAND = 6'd25, K_OR = 6'd26,   K_BITOR = 6'd27;
  localparam logic [5:0] K_DOT3 = 6'd28, K_CONCAT = 6'd29, K_DOT = 6'd30, K_BITXOR = 6'd31;
  localparam logic [5:0] K_BITNOT = 6'd32, K_LEN = 6'd33, K_SEMI = 6'd34, K_COLON = 6'd35;
  localparam logic [5:0] K_COMMA = 6'd36, K_LPAREN = 6'd37, K_RPAREN = 6'd38;
  localparam logic [5:0] K_LCURL = 6'd39, K_RCURL = 6'd40, K_LSQ = 6'd41, K_RSQ = 6'd42;
  localparam logic [5:0] K_ERROR = 6'd43, K_ID = 6'd44, K_FALSE = 6'd45, K_TRUE = 6'd46;
  localparam logic [5:0] K_NIL = 6'd47, K_LET = 6'd48, K_CONST = 6'd49, K_IF = 6'd50;
  localparam logic [5:0] K_ELSE = 6'd51, K_WHILE = 6'd52, K_FN = 6'd53, K_RETURN = 6'd54;
  localparam logic [5:0] K_BREAK = 6'd55, K_CONTINUE = 6'd56, K_FOR = 6'd57;
  localparam logic [5:0] K_INTEGER = 6'd58, K_FLOAT = 6'd59, K_STRING = 6'd60;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
  } tok_t;

  // All tokens caused by one input word
  typedef struct packed {
    tok_t [MAX_TOK-1:0] tok;
    logic [1:0]         cnt;
  } bundle_t;

  function automatic logic [15:0] clamp16(input logic [OFF_W-1:0] v);
    if (OFF_W > 16 && (v >> 16) != '0) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [OFF_W-1:0] s,
                                  input logic [OFF_W-1:0] e, input logic [15:0] line);
    tok_t t;
    t.kind  = kind;
    t.start = clamp16(s);
    t.len   = (e >= s) ? clamp16(e - s) : 16'd0;
    t.line  = line;
    return t;
  endfunction

endpackage

// File: design/stsc_in_if.sv
// Source byte channel.
interface stsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;
  modport source (output valid, char_byte, end_of_input, input ready);
  modport sink (input valid, char_byte, end_of_input, output ready);
endinterface

// File: design/stsc_tok_if.sv
// Token result channel.
interface stsc_tok_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic        last_of_run;
  modport source (output valid, token_kind, token_start, token_length, line_number,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, token_start, token_length, line_number,
                last_of_run, output ready);
endinterface

// File: design/stsc_cfg_if.sv
// Configuration write channel for the first line number.
interface stsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_line_number;
  modport source (output valid, first_line_number, input ready);
  modport sink (input valid, first_line_number, output ready);
endinterface

// File: design/stsc_front.sv
// Scanner front end: classifies each byte and builds the token words it causes.
module stsc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_byte,
  input  logic              end_of_input,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_line,
  output stsc_pkg::bundle_t bundle
);
  import stsc_pkg::*;

  localparam logic [4:0] M_IDLE = 5'd0, M_PLUS = 5'd1, M_MINUS = 5'd2, M_STAR = 5'd3;
  localparam logic [4:0] M_PERCENT = 5'd4, M_SLASH = 5'd5, M_EQ = 5'd6, M_BANG = 5'd7;
  localparam logic [4:0] M_GT = 5'd8, M_LT = 5'd9, M_LTLT = 5'd10, M_AMP = 5'd11;
  localparam logic [4:0] M_PIPE = 5'd12, M_DOT = 5'd13, M_DOTDOT = 5'd14, M_INT = 5'd15;
  localparam logic [4:0] M_INTDOT = 5'd16, M_FLOAT = 5'd17, M_IDENT = 5'd18;
  localparam logic [4:0] M_STRING = 5'd19, M_COMMENT = 5'd20;

  localparam logic [7:0] CH_TAB = 8'h09, CH_LF = 8'h0A, CH_CR = 8'h0D, CH_SP = 8'h20;
  localparam logic [7:0] CH_DQ = 8'h22, CH_SQ = 8'h27, CH_BSL = 8'h5C;

  localparam int NKW = 15;
  localparam logic [63:0] KW_WORD [NKW] = '{
    64'("false"), 64'("true"), 64'("nil"), 64'("or"), 64'("and"), 64'("let"),
    64'("const"), 64'("if"), 64'("else"), 64'("while"), 64'("fn"), 64'("return"),
    64'("break"), 64'("continue"), 64'("for")};
  localparam logic [3:0] KW_SIZE [NKW] = '{
    4'd5, 4'd4, 4'd3, 4'd2, 4'd3, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd5, 4'd8, 4'd3};
  localparam logic [5:0] KW_KIND [NKW] = '{
    K_FALSE, K_TRUE, K_NIL, K_OR, K_AND, K_LET, K_CONST, K_IF, K_ELSE, K_WHILE, K_FN,
    K_RETURN, K_BREAK, K_CONTINUE, K_FOR};

  typedef struct packed {
    logic [4:0]       mode;
    logic [OFF_W-1:0] tbeg;
    logic [15:0]      line;
    logic [63:0]      prefix;
    logic [7:0]       quote;
    logic             esc;
  } scan_st_t;

  typedef struct packed {
    scan_st_t st;
    logic     emit;
    tok_t     tok;
    logic     rerun;
  } step_t;

  scan_st_t         st;
  logic [OFF_W-1:0] off;
  logic [15:0]      first_line;

  function automatic logic [OFF_W-1:0] next_off(input logic [OFF_W-1:0] p);
    return (p == OFF_MAX) ? p : p + 1'b1;
  endfunction

  function automatic logic [15:0] line_inc(input logic [15:0] l);
    return (l == 16'hFFFF) ? l : l + 16'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [5:0] ident_kind(input logic [OFF_W-1:0] len,
                                            input logic [63:0] prefix);
    logic [5:0]  k;
    logic [63:0] mask;
    k = K_ID;
    for (int i = 0; i < NKW; i++) begin
      mask = (KW_SIZE[i] >= 4'd8) ? {64{1'b1}} : ((64'd1 << (KW_SIZE[i] * 8)) - 64'd1);
      if (len == OFF_W'(KW_SIZE[i]) && (prefix & mask) == KW_WORD[i] && k == K_ID)
        k = KW_KIND[i];
    end
    return k;
  endfunction

  // One pass of the mode machine over byte c at offset p
  function automatic step_t scan_step(input scan_st_t s, input logic [7:0] c,
                                      input logic [OFF_W-1:0] p);
    step_t            r;
    logic             dn;
    logic             ct;
    logic [5:0]       k;
    logic [OFF_W-1:0] np;
    logic [OFF_W-1:0] d;
    r       = '0;
    r.st    = s;
    dn      = 1'b0;
    ct      = 1'b0;
    k       = K_EOF;
    np      = next_off(p);
    d       = (p > s.tbeg) ? p - 1'b1 : p;
    unique case (s.mode)
      M_IDLE: begin
        case (c)
          CH_SP, CH_CR, CH_TAB: ;
          CH_LF: r.st.line = line_inc(s.line);
          "+": begin r.st.mode = M_PLUS;    r.st.tbeg = p; end
          "-": begin r.st.mode = M_MINUS;   r.st.tbeg = p; end
          "*": begin r.st.mode = M_STAR;    r.st.tbeg = p; end
          "%": begin r.st.mode = M_PERCENT; r.st.tbeg = p; end
          "/": begin r.st.mode = M_SLASH;   r.st.tbeg = p; end
          "=": begin r.st.mode = M_EQ;      r.st.tbeg = p; end
          "!": begin r.st.mode = M_BANG;    r.st.tbeg = p; end
          ">": begin r.st.mode = M_GT;      r.st.tbeg = p; end
          "<": begin r.st.mode = M_LT;      r.st.tbeg = p; end
          "&": begin r.st.mode = M_AMP;     r.st.tbeg = p; end
          "|": begin r.st.mode = M_PIPE;    r.st.tbeg = p; end
          ".": begin r.st.mode = M_DOT;     r.st.tbeg = p; end
          CH_SQ, CH_DQ: begin
            r.st.mode  = M_STRING;
            r.st.tbeg  = p;
            r.st.quote = c;
            r.st.esc   = 1'b0;
          end
          default: begin
            if (is_digit(c)) begin
              r.st.mode = M_INT;
              r.st.tbeg = p;
            end else if (is_alpha(c) || c == "_") begin
              r.st.mode   = M_IDENT;
              r.st.tbeg   = p;
              r.st.prefix = {56'd0, c};
            end else begin
              r.emit = 1'b1;
              case (c)
                "^":     k = K_BITXOR;
                "~":     k = K_BITNOT;
                "#":     k = K_LEN;
                ";":     k = K_SEMI;
                ":":     k = K_COLON;
                ",":     k = K_COMMA;
                "(":     k = K_LPAREN;
                ")":     k = K_RPAREN;
                "{":     k = K_LCURL;
                "}":     k = K_RCURL;
                "[":     k = K_LSQ;
                "]":     k = K_RSQ;
                default: k = K_ERROR;
              endcase
              r.tok = mk_tok(k, p, np, s.line);
            end
          end
        endcase
      end
      M_PLUS:    if (c == "=") begin dn = 1'b1; k = K_PLUSEQ; end
                 else begin ct = 1'b1; k = K_PLUS; end
      M_MINUS: begin
        if (c == "-") r.st.mode = M_COMMENT;
        else if (c == ">") begin dn = 1'b1; k = K_ARROW; end
        else if (c == "=") begin dn = 1'b1; k = K_MINUSEQ; end
        else begin ct = 1'b1; k = K_MINUS; end
      end
      M_STAR: begin
        if (c == "*") begin dn = 1'b1; k = K_EXP; end
        else if (c == "=") begin dn = 1'b1; k = K_MULTEQ; end
        else begin ct = 1'b1; k = K_MULT; end
      end
      M_PERCENT: if (c == "=") begin dn = 1'b1; k = K_MODEQ; end
                 else begin ct = 1'b1; k = K_MOD; end
      M_SLASH:   if (c == "=") begin dn = 1'b1; k = K_DIVEQ; end
                 else begin ct = 1'b1; k = K_DIV; end
      M_EQ:      if (c == "=") begin dn = 1'b1; k = K_EQEQ; end
                 else begin ct = 1'b1; k = K_EQ; end
      M_BANG:    if (c == "=") begin dn = 1'b1; k = K_BANGEQ; end
                 else begin ct = 1'b1; k = K_BANG; end
      M_GT: begin
        if (c == "=") begin dn = 1'b1; k = K_GTEQ; end
        else if (c == ">") begin dn = 1'b1; k = K_RSHIFT; end
        else begin ct = 1'b1; k = K_GT; end
      end
      M_LT: begin
        if (c == "=") begin dn = 1'b1; k = K_LTEQ; end
        else if (c == "<") r.st.mode = M_LTLT;
        else begin ct = 1'b1; k = K_LT; end
      end
      M_LTLT:    if (c == "<") begin dn = 1'b1; k = K_APPEND; end
                 else begin ct = 1'b1; k = K_LSHIFT; end
      M_AMP:     if (c == "&") begin dn = 1'b1; k = K_AND; end
                 else begin ct = 1'b1; k = K_BITAND; end
      M_PIPE:    if (c == "|") begin dn = 1'b1; k = K_OR; end
                 else begin ct = 1'b1; k = K_BITOR; end
      M_DOT:     if (c == ".") r.st.mode = M_DOTDOT;
                 else begin ct = 1'b1; k = K_DOT; end
      M_DOTDOT:  if (c == ".") begin dn = 1'b1; k = K_DOT3; end
                 else begin ct = 1'b1; k = K_CONCAT; end
      M_INT: begin
        if (c == ".") r.st.mode = M_INTDOT;
        else if (!is_digit(c)) begin ct = 1'b1; k = K_INTEGER; end
      end
      M_INTDOT: begin
        if (is_digit(c)) begin
          r.st.mode = M_FLOAT;
        end else begin
          // split "1." into the integer and a pending dot, then rerun the byte
          r.emit    = 1'b1;
          r.tok     = mk_tok(K_INTEGER, s.tbeg, d, s.line);
          r.st.tbeg = d;
          r.st.mode = M_DOT;
          r.rerun   = 1'b1;
        end
      end
      M_FLOAT:   if (!is_digit(c)) begin ct = 1'b1; k = K_FLOAT; end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") r.st.prefix = {s.prefix[55:0], c};
        else begin ct = 1'b1; k = ident_kind(p - s.tbeg, s.prefix); end
      end
      M_STRING: begin
        if (c == CH_LF) r.st.line = line_inc(s.line);
        if (s.esc) r.st.esc = 1'b0;
        else if (c == s.quote) begin dn = 1'b1; k = K_STRING; end
        else if (c == CH_BSL) r.st.esc = 1'b1;
      end
      M_COMMENT: begin
        if (c == CH_LF || c == CH_CR) begin
          r.st.mode = M_IDLE;
          r.rerun   = 1'b1;
        end
      end
      default: begin
        r.st.mode = M_IDLE;
        r.rerun   = 1'b1;
      end
    endcase
    // close the pending token with or without this byte
    if (dn || ct) begin
      r.emit    = 1'b1;
      r.tok     = mk_tok(k, s.tbeg, dn ? np : p, s.line);
      r.st.mode = M_IDLE;
      r.rerun   = ct;
    end
    return r;
  endfunction

  step_t            r1, r2, r3;
  logic             run2, run3;
  scan_st_t         st_next;
  logic [OFF_W-1:0] off_next;
  logic [OFF_W-1:0] fd;
  logic             fe;
  logic [5:0]       fk;
  logic [1:0]       n;

  // Run up to three passes of the byte, or flush at end of input or on a zero byte
  always_comb begin
    r1       = scan_step(st, char_byte, off);
    run2     = r1.rerun;
    r2       = scan_step(r1.st, char_byte, off);
    run3     = run2 && r2.rerun;
    r3       = scan_step(r2.st, char_byte, off);
    bundle   = '0;
    n        = 2'd0;
    fd       = (off > st.tbeg) ? off - 1'b1 : off;
    fe       = 1'b1;
    fk       = K_EOF;
    st_next  = st;
    off_next = off;
    if (end_of_input || char_byte == 8'd0) begin
      unique case (st.mode)
        M_IDLE, M_COMMENT: fe = 1'b0;
        M_INT:    fk = K_INTEGER;
        M_FLOAT:  fk = K_FLOAT;
        M_IDENT:  fk = ident_kind(off - st.tbeg, st.prefix);
        M_STRING: fk = K_ERROR;
        M_INTDOT: fe = 1'b0;
        M_PLUS:    fk = K_PLUS;
        M_MINUS:   fk = K_MINUS;
        M_STAR:    fk = K_MULT;
        M_PERCENT: fk = K_MOD;
        M_SLASH:   fk = K_DIV;
        M_EQ:      fk = K_EQ;
        M_BANG:    fk = K_BANG;
        M_GT:      fk = K_GT;
        M_LT:      fk = K_LT;
        M_LTLT:    fk = K_LSHIFT;
        M_AMP:     fk = K_BITAND;
        M_PIPE:    fk = K_BITOR;
        M_DOT:     fk = K_DOT;
        M_DOTDOT:  fk = K_CONCAT;
        default:   fe = 1'b0;
      endcase
      if (st.mode == M_INTDOT) begin
        bundle.tok[0] = mk_tok(K_INTEGER, st.tbeg, fd, st.line);
        bundle.tok[1] = mk_tok(K_DOT, fd, off, st.line);
        n             = 2'd2;
      end else if (fe) begin
        bundle.tok[0] = mk_tok(fk, st.tbeg, off, st.line);
        n             = 2'd1;
      end
      bundle.tok[n] = mk_tok(K_EOF, off, off, st.line);
      n             = n + 2'd1;
      // restart for a new source
      st_next        = '0;
      st_next.mode   = M_IDLE;
      st_next.line   = first_line;
      off_next       = '0;
    end else begin
      if (r1.emit) begin
        bundle.tok[n] = r1.tok;
        n             = n + 2'd1;
      end
      if (run2 && r2.emit) begin
        bundle.tok[n] = r2.tok;
        n             = n + 2'd1;
      end
      if (run3 && r3.emit) begin
        bundle.tok[n] = r3.tok;
        n             = n + 2'd1;
      end
      st_next  = run3 ? r3.st : (run2 ? r2.st : r1.st);
      off_next = next_off(off);
    end
    bundle.cnt = n;
  end

  // Advance scan state on each accepted word; the line setting takes effect at the next end
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '{mode: M_IDLE, tbeg: '0, line: 16'd1, prefix: '0, quote: '0, esc: 1'b0};
      off        <= '0;
      first_line <= 16'd1;
    end else begin
      if (accept) begin
        st  <= st_next;
        off <= off_next;
      end
      if (cfg_we) begin
        first_line <= cfg_line;
      end
    end
  end

endmodule

// File: design/stsc_queue.sv
// Short queue of token bundles between the front end and the output stage.
module stsc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stsc_pkg::bundle_t wdata,
  input  logic              pop,
  output stsc_pkg::bundle_t rdata,
  output logic              full,
  output logic              empty
);
  import stsc_pkg::*;

  bundle_t       mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr, rptr;
  logic [Q_AW:0]   count;

  assign full  = count == (Q_AW+1)'(Q_DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count out of range");
  a_empty_push: assert property (@(posedge clk) disable iff (rst)
    empty && push |=> !empty)
    else $error("queue lost a word");

endmodule

// File: design/stsc_back.sv
// Output stage: hands out the tokens of each bundle one word per cycle while tok.ready is high.
module stsc_back (
  input  logic              clk,
  input  logic              rst,
  input  stsc_pkg::bundle_t head,
  input  logic              q_empty,
  output logic              pop,
  stsc_tok_if.source        tok
);
  import stsc_pkg::*;

  bundle_t    cur;
  logic [1:0] idx;
  logic       have;
  logic       last;
  logic       take;
  tok_t       t;

  assign t    = cur.tok[idx];
  assign last = idx == cur.cnt - 2'd1;
  assign take = !have || (tok.valid && tok.ready && last);
  assign pop  = take && !q_empty;

  assign tok.valid        = have;
  assign tok.token_kind   = t.kind;
  assign tok.token_start  = t.start;
  assign tok.token_length = t.len;
  assign tok.line_number  = t.line;
  assign tok.last_of_run  = last;

  // Load next bundle or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      have <= 1'b1;
      idx  <= 2'd0;
    end else if (take) begin
      have <= 1'b0;
    end else if (tok.valid && tok.ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst) have |-> cur.cnt != 2'd0)
    else $error("empty bundle in output stage");
  a_idx_range: assert property (@(posedge clk) disable iff (rst) have |-> idx < cur.cnt)
    else $error("token index past bundle");
  a_step: assert property (@(posedge clk) disable iff (rst)
    tok.valid && tok.ready && !last |=> have && idx == $past(idx) + 2'd1)
    else $error("token skipped");

endmodule

// File: design/script_token_scanner.sv
// Script token scanner top level.
//
// Channels: src takes one source byte per word (char_byte, end_of_input);
// tok gives one token per word (kind, start, length, line, last_of_run);
// cfg writes first_line_number, taken at any time, meant while idle; the
// line count picks up the new value at the next end of source.
// A byte (or an end flag / zero byte) yields zero to three tokens; the
// last token of each byte carries last_of_run.
// The front end takes one byte per cycle while the bundle queue (four
// entries) has room, so bytes stream at 1 per cycle. Tokens leave at
// one per cycle from the output register while the receiver is ready,
// so the tokens of one byte leave one after another.
// The first token of a byte is written into the queue at the accepting
// edge and then loaded into the output register, which drives tok; it
// waits in the queue while the output stage still holds earlier tokens.
// Reset: offsets clear, line count and first_line_number go to 1, the
// queue empties and tok.valid drops.
// When the receiver stalls, the current token holds, the queue fills and
// src.ready falls once all four entries are in use.
module script_token_scanner (
  input logic        clk,
  input logic        rst,
  stsc_in_if.sink    src,
  stsc_tok_if.source tok,
  stsc_cfg_if.sink   cfg
);
  import stsc_pkg::*;

  bundle_t bundle, head;
  logic    full, empty, pop, accept;

  assign src.ready = !full;
  assign cfg.ready = 1'b1;
  assign accept    = src.valid && src.ready;

  stsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_byte    (src.char_byte),
    .end_of_input (src.end_of_input),
    .cfg_we       (cfg.valid && cfg.ready),
    .cfg_line     (cfg.first_line_number),
    .bundle       (bundle)
  );

  stsc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept && bundle.cnt != 2'd0),
    .wdata (bundle),
    .pop   (pop),
    .rdata (head),
    .full  (full),
    .empty (empty)
  );

  stsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (empty),
    .pop     (pop),
    .tok     (tok)
  );

endmodule
